/* rtl/pse_pkg.sv */
// Shared types and constants of the process schedule evaluator.
// Used by every module of the block but pse_ram; depends on nothing.
`default_nettype none

package pse_pkg;

   localparam int MAX_PROCS_DEF = 16;

   localparam int ID_W   = 16;
   localparam int ARR_W  = 16;
   localparam int BUR_W  = 16;
   localparam int URG_W  = 8;
   localparam int TIME_W = 21;
   localparam int REC_W  = ID_W + ARR_W + BUR_W + URG_W;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int POLICY_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_SLICE = 1'd1;

   localparam logic [POLICY_W-1:0] POL_FCFS     = 2'd0;
   localparam logic [POLICY_W-1:0] POL_SHORTEST = 2'd1;
   localparam logic [POLICY_W-1:0] POL_PRIORITY = 2'd2;
   localparam logic [POLICY_W-1:0] POL_ROBIN    = 2'd3;

   localparam logic [BUR_W-1:0] SLICE_RESET = 16'd2;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [ARR_W-1:0] arr;
      logic [BUR_W-1:0] bur;
      logic [URG_W-1:0] urg;
   } rec_type;

   typedef struct packed {
      logic load;
      logic start;
      logic scan_init;
      logic scan_step;
      logic jump;
      logic select;
      logic fetch;
      logic exec;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic have_pick;
      logic exec_finish;
      logic set_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/pse_ram.sv */
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`default_nettype none

module pse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/pse_ctrl.sv */
// Sequencer of the process schedule evaluator: loading, scan passes, picks and results.
// Depends on pse_pkg.
`default_nettype none

module pse_ctrl
   import pse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last_proc,
   input  wire status_type status,
   output logic            req_stall,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_LOAD, S_START, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_FETCH, S_EXEC, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;
   logic      accept;

   assign accept    = req_valid && !stall_ff;
   assign req_stall = stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_last_proc) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cmd.start     = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_SCAN_WAIT;
            end
         end
         S_SCAN_WAIT: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.have_pick) begin
               cmd.select = 1'b1;
               state_in   = S_FETCH;
            end else begin
               cmd.jump      = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.exec_finish) begin
               state_in = S_EMIT;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.set_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != S_LOAD);
      end
   end

endmodule

`default_nettype wire

/* rtl/pse_datapath.sv */
// Datapath of the process schedule evaluator: tables, scan accumulators, clock and results.
// Depends on pse_pkg and pse_ram.
`default_nettype none

module pse_datapath
   import pse_pkg::*;
#(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [ID_W-1:0]        req_proc_id,
   input  wire logic [ARR_W-1:0]       req_arrival,
   input  wire logic [BUR_W-1:0]       req_burst,
   input  wire logic [URG_W-1:0]       req_urgency,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [ID_W-1:0]        rsp_out_id,
   output logic      [ARR_W-1:0]       rsp_out_arrival,
   output logic      [BUR_W-1:0]       rsp_out_burst,
   output logic      [TIME_W-1:0]      rsp_completion,
   output logic      [TIME_W-1:0]      rsp_turnaround,
   output logic      [TIME_W-1:0]      rsp_waiting,
   output logic                        rsp_final_result
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   logic [POLICY_W-1:0] policy_ff;
   logic [BUR_W-1:0]    slice_ff;
   logic [CNT_W-1:0]    count_ff, finished_ff;
   logic [IDX_W-1:0]    scan_idx_ff, rd_idx_ff, pick_idx_ff, thr_idx_ff;
   logic                scan_vld_ff;
   logic [MAX_PROCS-1:0] done_ff;
   logic [TIME_W-1:0]   clock_ff;
   logic                from_start_ff;
   logic [ARR_W-1:0]    thr_arr_ff;

   logic                b_found_ff, f_found_ff, e_found_ff;
   logic [BUR_W-1:0]    b_key_ff;
   logic [ARR_W-1:0]    b_arr_ff, f_arr_ff, e_arr_ff;
   logic [IDX_W-1:0]    b_idx_ff, f_idx_ff;

   logic [ID_W-1:0]     pick_id_ff;
   logic [ARR_W-1:0]    pick_arr_ff;
   logic [BUR_W-1:0]    pick_bur_ff;

   logic                is_robin, full;
   logic [IDX_W-1:0]    rd_addr, rem_wr_addr;
   logic                tab_wr_en, rem_wr_en;
   logic [BUR_W-1:0]    rem_wr_data, rem_rd, quantum, key;
   logic [REC_W-1:0]    tab_rd_bits;
   rec_type             wr_rec, rd_rec;
   logic                pend, arrived, elig, after_thr, finish;
   logic [BUR_W-1:0]    step;
   logic [TIME_W-1:0]   tat;

   assign is_robin = (policy_ff == POL_ROBIN);
   assign full     = (count_ff == CNT_W'(MAX_PROCS));
   assign quantum  = (slice_ff == '0) ? BUR_W'(1) : slice_ff;

   assign wr_rec.id  = req_proc_id;
   assign wr_rec.arr = req_arrival;
   assign wr_rec.bur = req_burst;
   assign wr_rec.urg = req_urgency;
   assign tab_wr_en  = cmd.load && !full;
   assign rd_addr    = cmd.fetch ? pick_idx_ff : scan_idx_ff;

   pse_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_tab (
      .clock  (clock),
      .wr_en  (tab_wr_en),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data(wr_rec),
      .rd_addr(rd_addr),
      .rd_data(tab_rd_bits)
   );

   assign rd_rec = rec_type'(tab_rd_bits);

   assign finish      = !is_robin || (rem_rd <= quantum);
   assign step        = finish ? rem_rd : quantum;
   assign rem_wr_en   = tab_wr_en || (cmd.exec && !finish);
   assign rem_wr_addr = cmd.exec ? pick_idx_ff : count_ff[IDX_W-1:0];
   assign rem_wr_data = cmd.exec ? (rem_rd - quantum) : req_burst;

   pse_ram #(.WIDTH(BUR_W), .DEPTH(MAX_PROCS)) u_rem (
      .clock  (clock),
      .wr_en  (rem_wr_en),
      .wr_addr(rem_wr_addr),
      .wr_data(rem_wr_data),
      .rd_addr(pick_idx_ff),
      .rd_data(rem_rd)
   );

   always_comb begin
      case (policy_ff)
         POL_SHORTEST: key = rd_rec.bur;
         POL_PRIORITY: key = BUR_W'(rd_rec.urg);
         default:      key = rd_rec.arr;
      endcase
   end

   assign pend      = !done_ff[rd_idx_ff];
   assign arrived   = (TIME_W'(rd_rec.arr) <= clock_ff);
   assign elig      = pend && arrived;
   assign after_thr = (rd_rec.arr > thr_arr_ff) ||
                      ((rd_rec.arr == thr_arr_ff) && (rd_idx_ff > thr_idx_ff));

   assign tat = clock_ff - TIME_W'(pick_arr_ff);

   assign status.scan_last   = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);
   assign status.have_pick   = b_found_ff;
   assign status.exec_finish = finish;
   assign status.set_last    = ((finished_ff + CNT_W'(1)) == count_ff);
   assign status.out_free    = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POL_FCFS;
         slice_ff      <= SLICE_RESET;
         count_ff      <= '0;
         finished_ff   <= '0;
         done_ff       <= '0;
         clock_ff      <= '0;
         from_start_ff <= 1'b1;
         scan_vld_ff   <= 1'b0;
         b_found_ff    <= 1'b0;
         f_found_ff    <= 1'b0;
         e_found_ff    <= 1'b0;
         rsp_valid     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_POLICY) begin
               policy_ff <= csr_wdata[POLICY_W-1:0];
            end else if (csr_index == CSR_TIME_SLICE) begin
               slice_ff <= csr_wdata[BUR_W-1:0];
            end
         end
         if (tab_wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.start) begin
            clock_ff      <= '0;
            finished_ff   <= '0;
            from_start_ff <= 1'b1;
         end
         scan_vld_ff <= cmd.scan_step;
         if (cmd.scan_init) begin
            b_found_ff <= 1'b0;
            f_found_ff <= 1'b0;
            e_found_ff <= 1'b0;
         end else if (scan_vld_ff) begin
            if (pend && (!e_found_ff || rd_rec.arr < e_arr_ff)) begin
               e_found_ff <= 1'b1;
            end
            if (elig && (!b_found_ff || key < b_key_ff ||
                         (key == b_key_ff && rd_rec.arr < b_arr_ff))) begin
               b_found_ff <= 1'b1;
            end
            if (elig && after_thr && (!f_found_ff || rd_rec.arr < f_arr_ff)) begin
               f_found_ff <= 1'b1;
            end
         end
         if (cmd.jump) begin
            clock_ff      <= TIME_W'(e_arr_ff);
            from_start_ff <= 1'b1;
         end
         if (cmd.exec) begin
            clock_ff      <= clock_ff + TIME_W'(step);
            from_start_ff <= 1'b0;
            if (finish) begin
               done_ff[pick_idx_ff] <= 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid   <= 1'b1;
            finished_ff <= finished_ff + CNT_W'(1);
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         if (cmd.clear) begin
            count_ff <= '0;
            done_ff  <= '0;
            clock_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
      rd_idx_ff <= scan_idx_ff;
      if (!cmd.scan_init && scan_vld_ff) begin
         if (pend && (!e_found_ff || rd_rec.arr < e_arr_ff)) begin
            e_arr_ff <= rd_rec.arr;
         end
         if (elig && (!b_found_ff || key < b_key_ff ||
                      (key == b_key_ff && rd_rec.arr < b_arr_ff))) begin
            b_key_ff <= key;
            b_arr_ff <= rd_rec.arr;
            b_idx_ff <= rd_idx_ff;
         end
         if (elig && after_thr && (!f_found_ff || rd_rec.arr < f_arr_ff)) begin
            f_arr_ff <= rd_rec.arr;
            f_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.select) begin
         pick_idx_ff <= (is_robin && !from_start_ff && f_found_ff) ? f_idx_ff : b_idx_ff;
      end
      if (cmd.exec) begin
         pick_id_ff  <= rd_rec.id;
         pick_arr_ff <= rd_rec.arr;
         pick_bur_ff <= rd_rec.bur;
         thr_arr_ff  <= rd_rec.arr;
         thr_idx_ff  <= pick_idx_ff;
      end
      if (cmd.emit) begin
         rsp_out_id       <= pick_id_ff;
         rsp_out_arrival  <= pick_arr_ff;
         rsp_out_burst    <= pick_bur_ff;
         rsp_completion   <= clock_ff;
         rsp_turnaround   <= tat;
         rsp_waiting      <= tat - TIME_W'(pick_bur_ff);
         rsp_final_result <= status.set_last;
      end
   end

endmodule

`default_nettype wire

/* rtl/process_schedule_evaluator.sv */
// Top level of the process schedule evaluator: sequencer plus datapath.
// Depends on pse_pkg, pse_ctrl, pse_datapath and pse_ram.
`default_nettype none

// Records load at one request per cycle until one marked last_proc arrives; the block then
// stalls its input and schedules the stored set. Each scheduling decision is one pass over
// the n stored records through the table's single read port followed by wait, decide, fetch,
// execute and emit steps. An idle gap costs an extra pass that ends in a clock jump to the
// earliest pending arrival, and a partial round robin slice costs a pass that ends after
// the execute step. Input is taken again only once the last result of the set has been
// emitted, after any waits on the result channel.
module process_schedule_evaluator
   import pse_pkg::*;
#(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [ID_W-1:0]        req_proc_id,
   input  wire logic [ARR_W-1:0]       req_arrival,
   input  wire logic [BUR_W-1:0]       req_burst,
   input  wire logic [URG_W-1:0]       req_urgency,
   input  wire logic                   req_last_proc,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [ID_W-1:0]        rsp_out_id,
   output logic      [ARR_W-1:0]       rsp_out_arrival,
   output logic      [BUR_W-1:0]       rsp_out_burst,
   output logic      [TIME_W-1:0]      rsp_completion,
   output logic      [TIME_W-1:0]      rsp_turnaround,
   output logic      [TIME_W-1:0]      rsp_waiting,
   output logic                        rsp_final_result
);

   cmd_type    cmd;
   status_type status;

   pse_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_proc(req_last_proc),
      .status       (status),
      .req_stall    (req_stall),
      .cmd          (cmd)
   );

   pse_datapath #(.MAX_PROCS(MAX_PROCS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_proc_id     (req_proc_id),
      .req_arrival     (req_arrival),
      .req_burst       (req_burst),
      .req_urgency     (req_urgency),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_arrival (rsp_out_arrival),
      .rsp_out_burst   (rsp_out_burst),
      .rsp_completion  (rsp_completion),
      .rsp_turnaround  (rsp_turnaround),
      .rsp_waiting     (rsp_waiting),
      .rsp_final_result(rsp_final_result)
   );

endmodule

`default_nettype wire

/* rtl/pse_checker.sv */
// Port-level checks of the process schedule evaluator and their binding to the top level.
// Depends on pse_pkg and process_schedule_evaluator.
`default_nettype none

module pse_checker
   import pse_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [ID_W-1:0]   rsp_out_id,
   input wire logic [ARR_W-1:0]  rsp_out_arrival,
   input wire logic [BUR_W-1:0]  rsp_out_burst,
   input wire logic [TIME_W-1:0] rsp_completion,
   input wire logic [TIME_W-1:0] rsp_turnaround,
   input wire logic [TIME_W-1:0] rsp_waiting,
   input wire logic              rsp_final_result
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_id) && $stable(rsp_completion))
      else $error("stalled result changed");

   a_busy_until_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_result |-> req_stall)
      else $error("request taken while a set is still being reported");

   a_turnaround: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_turnaround == TIME_W'(rsp_completion - TIME_W'(rsp_out_arrival)))
      else $error("turnaround mismatch");

   a_waiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_waiting == TIME_W'(rsp_turnaround - TIME_W'(rsp_out_burst)))
      else $error("waiting time mismatch");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind process_schedule_evaluator pse_checker u_pse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_id      (rsp_out_id),
   .rsp_out_arrival (rsp_out_arrival),
   .rsp_out_burst   (rsp_out_burst),
   .rsp_completion  (rsp_completion),
   .rsp_turnaround  (rsp_turnaround),
   .rsp_waiting     (rsp_waiting),
   .rsp_final_result(rsp_final_result)
);

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench of process_schedule_evaluator: record sets are loaded under every
// scheduling policy and the per-process results are compared against an in-bench scheduler.
// Depends on pse_pkg and the process_schedule_evaluator RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import pse_pkg::*;

   typedef struct {
      logic [ID_W-1:0]   id;
      logic [ARR_W-1:0]  arr;
      logic [BUR_W-1:0]  bur;
      logic [TIME_W-1:0] comp;
      logic [TIME_W-1:0] tat;
      logic [TIME_W-1:0] wt;
      logic              fin;
   } finish_rec_t;

   typedef struct {
      bit                    cfg_en;
      logic [POLICY_W-1:0]   pol;
      logic [BUR_W-1:0]      slc;
      rec_type               r;
      logic                  last;
      bit                    has_exp;
      logic [TIME_W-1:0]     comp;
      logic [TIME_W-1:0]     tat;
      logic [TIME_W-1:0]     wt;
   } stim_row_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_POLICY;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ID_W-1:0]        req_proc_id = '0;
   logic [ARR_W-1:0]       req_arrival = '0;
   logic [BUR_W-1:0]       req_burst = '0;
   logic [URG_W-1:0]       req_urgency = '0;
   logic                   req_last_proc = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ID_W-1:0]        rsp_out_id;
   logic [ARR_W-1:0]       rsp_out_arrival;
   logic [BUR_W-1:0]       rsp_out_burst;
   logic [TIME_W-1:0]      rsp_completion;
   logic [TIME_W-1:0]      rsp_turnaround;
   logic [TIME_W-1:0]      rsp_waiting;
   logic                   rsp_final_result;

   finish_rec_t         finish_q[$];
   int                  error_count = 0;
   int                  burst_left = 0;
   int                  request_count = 0;
   bit                  hold_request = 1'b0;

   rec_type             proc_tbl[MAX_PROCS_DEF];
   logic [BUR_W-1:0]    remain_time[MAX_PROCS_DEF];
   bit                  proc_done[MAX_PROCS_DEF];
   int                  proc_cnt = 0;
   logic [POLICY_W-1:0] cur_policy = POL_FCFS;
   logic [BUR_W-1:0]    cur_slice = SLICE_RESET;

   process_schedule_evaluator i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_proc_id(req_proc_id), .req_arrival(req_arrival), .req_burst(req_burst),
      .req_urgency(req_urgency), .req_last_proc(req_last_proc),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_id(rsp_out_id), .rsp_out_arrival(rsp_out_arrival),
      .rsp_out_burst(rsp_out_burst), .rsp_completion(rsp_completion),
      .rsp_turnaround(rsp_turnaround), .rsp_waiting(rsp_waiting),
      .rsp_final_result(rsp_final_result)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [BUR_W-1:0] sort_key(int i);
      case (cur_policy)
         POL_SHORTEST: return proc_tbl[i].bur;
         POL_PRIORITY: return {{(BUR_W-URG_W){1'b0}}, proc_tbl[i].urg};
         default:      return proc_tbl[i].arr;
      endcase
   endfunction

   task automatic log_finish(int i, logic [TIME_W-1:0] c);
      finish_rec_t f;
      f.id   = proc_tbl[i].id;
      f.arr  = proc_tbl[i].arr;
      f.bur  = proc_tbl[i].bur;
      f.comp = c;
      f.tat  = c - TIME_W'(proc_tbl[i].arr);
      f.wt   = f.tat - TIME_W'(proc_tbl[i].bur);
      f.fin  = 1'b0;
      finish_q.push_back(f);
   endtask

   task automatic schedule_set();
      int                n, k, best, pick, idx, finished, pos, j, v, t;
      int                ord[MAX_PROCS_DEF];
      logic [TIME_W-1:0] now;
      logic [BUR_W-1:0]  quantum;
      n = proc_cnt;
      now = '0;
      if (cur_policy == POL_ROBIN) begin
         quantum = (cur_slice == 0) ? 16'd1 : cur_slice;
         for (int i = 0; i < n; i++) begin
            v = i;
            j = i;
            while (j > 0 && proc_tbl[ord[j-1]].arr > proc_tbl[v].arr) begin
               ord[j] = ord[j-1];
               j--;
            end
            ord[j] = v;
         end
         pos = 0;
         finished = 0;
         while (finished < n) begin
            pick = -1;
            for (j = 0; j < n; j++) begin
               t = (pos + j) % n;
               if (!proc_done[ord[t]] && TIME_W'(proc_tbl[ord[t]].arr) <= now) begin
                  pick = t;
                  break;
               end
            end
            if (pick < 0) begin
               for (j = 0; j < n; j++) begin
                  if (!proc_done[ord[j]]) begin
                     now = TIME_W'(proc_tbl[ord[j]].arr);
                     pos = j;
                     break;
                  end
               end
               continue;
            end
            idx = ord[pick];
            if (remain_time[idx] <= quantum) begin
               now = now + TIME_W'(remain_time[idx]);
               remain_time[idx] = '0;
               proc_done[idx] = 1'b1;
               log_finish(idx, now);
               finished++;
            end else begin
               remain_time[idx] = remain_time[idx] - quantum;
               now = now + TIME_W'(quantum);
            end
            pos = (pick + 1) % n;
         end
      end else begin
         k = 0;
         while (k < n) begin
            best = -1;
            for (int i = 0; i < n; i++) begin
               if (proc_done[i] || TIME_W'(proc_tbl[i].arr) > now) continue;
               if (best < 0 || sort_key(i) < sort_key(best) ||
                   (sort_key(i) == sort_key(best) && proc_tbl[i].arr < proc_tbl[best].arr))
                  best = i;
            end
            if (best < 0) begin
               for (int i = 0; i < n; i++) begin
                  if (!proc_done[i] && (best < 0 || proc_tbl[i].arr < proc_tbl[best].arr))
                     best = i;
               end
               now = TIME_W'(proc_tbl[best].arr);
               continue;
            end
            now = now + TIME_W'(proc_tbl[best].bur);
            proc_done[best] = 1'b1;
            log_finish(best, now);
            k++;
         end
      end
      finish_q[finish_q.size()-1].fin = 1'b1;
      proc_cnt = 0;
   endtask

   task automatic take_request(rec_type r, logic last);
      if (proc_cnt < MAX_PROCS_DEF) begin
         proc_tbl[proc_cnt] = r;
         remain_time[proc_cnt] = r.bur;
         proc_done[proc_cnt] = 1'b0;
         proc_cnt++;
      end
      if (last && proc_cnt > 0) schedule_set();
   endtask

   task automatic send_request(rec_type r, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid     <= 1'b1;
      req_proc_id   <= r.id;
      req_arrival   <= r.arr;
      req_burst     <= r.bur;
      req_urgency   <= r.urg;
      req_last_proc <= last;
      do @(posedge clock); while (req_stall);
      burst_left--;
      request_count++;
      take_request(r, last);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (finish_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_config(logic [POLICY_W-1:0] pol, logic [BUR_W-1:0] slc);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_POLICY;
      csr_wdata <= CSR_DATA_W'(pol);
      @(posedge clock);
      csr_index <= CSR_TIME_SLICE;
      csr_wdata <= slc;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_policy = pol;
      cur_slice = slc;
   endtask

   function automatic rec_type random_record(logic [BUR_W-1:0] slc);
      rec_type r;
      int      eff;
      r.id  = ID_W'($urandom());
      r.arr = ($urandom_range(0, 1) == 0) ? ARR_W'($urandom_range(0, 30)) : ARR_W'($urandom());
      r.urg = ($urandom_range(0, 1) == 0) ? URG_W'($urandom_range(0, 3)) : URG_W'($urandom());
      case ($urandom_range(0, 9))
         0:       r.bur = '0;
         1, 2, 3: r.bur = BUR_W'($urandom());
         default: r.bur = BUR_W'($urandom_range(1, 40));
      endcase
      eff = (slc == 0) ? 1 : int'(slc);
      if (cur_policy == POL_ROBIN && eff < 4096 && r.bur > 8 * eff)
         r.bur = BUR_W'($urandom_range(0, 8 * eff));
      return r;
   endfunction

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (finish_q.size() == 0) begin
            $display("%0t: unexpected result id %h", $time, rsp_out_id);
            error_count++;
         end else begin
            finish_rec_t e;
            e = finish_q.pop_front();
            if (rsp_out_id !== e.id) begin
               $display("%0t: out_id exp %h got %h", $time, e.id, rsp_out_id);
               error_count++;
            end
            if (rsp_out_arrival !== e.arr) begin
               $display("%0t: out_arrival exp %h got %h", $time, e.arr, rsp_out_arrival);
               error_count++;
            end
            if (rsp_out_burst !== e.bur) begin
               $display("%0t: out_burst exp %h got %h", $time, e.bur, rsp_out_burst);
               error_count++;
            end
            if (rsp_completion !== e.comp) begin
               $display("%0t: completion exp %0d got %0d", $time, e.comp, rsp_completion);
               error_count++;
            end
            if (rsp_turnaround !== e.tat) begin
               $display("%0t: turnaround exp %0d got %0d", $time, e.tat, rsp_turnaround);
               error_count++;
            end
            if (rsp_waiting !== e.wt) begin
               $display("%0t: waiting exp %0d got %0d", $time, e.wt, rsp_waiting);
               error_count++;
            end
            if (rsp_final_result !== e.fin) begin
               $display("%0t: final_result exp %b got %b", $time, e.fin, rsp_final_result);
               error_count++;
            end
         end
      end
   end

   int unsigned stall_cycle = 0;
   int          hold_left = 0;
   always @(posedge clock) begin
      stall_cycle++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 2000;
         rsp_stall <= 1'b1;
      end else begin
         case ((stall_cycle / 64) % 3)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   initial begin
      #10_000_000;
      $display("FAIL process_schedule_evaluator");
      $finish;
   end

   initial begin
      stim_row_t        rows[$];
      stim_row_t        row;
      rec_type          r;
      logic [BUR_W-1:0] slc;
      int               phase, set_size;
      rows = '{
         '{0, POL_FCFS, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1, 1, 131070, 65535, 0},
         '{0, POL_FCFS, 0, '{16'h0000, 16'h0000, 16'h0000, 8'h00}, 1, 1, 0, 0, 0},
         '{0, POL_FCFS, 0, '{16'h0001, 16'h0000, 16'h0001, 8'h00}, 1, 1, 1, 1, 0},
         '{0, POL_FCFS, 0, '{16'hAAAA, 16'h0005, 16'h0003, 8'hAA}, 0, 0, 0, 0, 0},
         '{0, POL_FCFS, 0, '{16'h5555, 16'h0005, 16'h0003, 8'h55}, 0, 0, 0, 0, 0},
         '{0, POL_FCFS, 0, '{16'h000C, 16'h0002, 16'h0004, 8'h01}, 0, 0, 0, 0, 0},
         '{0, POL_FCFS, 0, '{16'h000D, 16'h0028, 16'h0002, 8'h09}, 1, 0, 0, 0, 0},
         '{1, POL_SHORTEST, 2, '{16'd20, 16'd0, 16'd9, 8'd0}, 0, 0, 0, 0, 0},
         '{0, POL_SHORTEST, 2, '{16'd21, 16'd1, 16'd2, 8'd5}, 0, 0, 0, 0, 0},
         '{0, POL_SHORTEST, 2, '{16'd22, 16'd1, 16'd2, 8'd3}, 0, 0, 0, 0, 0},
         '{0, POL_SHORTEST, 2, '{16'd23, 16'd100, 16'd1, 8'd0}, 1, 0, 0, 0, 0},
         '{1, POL_PRIORITY, 2, '{16'd30, 16'd3, 16'd4, 8'd7}, 0, 0, 0, 0, 0},
         '{0, POL_PRIORITY, 2, '{16'd31, 16'd0, 16'd6, 8'd7}, 0, 0, 0, 0, 0},
         '{0, POL_PRIORITY, 2, '{16'd32, 16'd2, 16'd1, 8'd0}, 1, 0, 0, 0, 0},
         '{1, POL_ROBIN, 0, '{16'd40, 16'd0, 16'd3, 8'd0}, 0, 0, 0, 0, 0},
         '{0, POL_ROBIN, 0, '{16'd41, 16'd1, 16'd2, 8'd0}, 0, 0, 0, 0, 0},
         '{0, POL_ROBIN, 0, '{16'd42, 16'd50, 16'd1, 8'd0}, 1, 0, 0, 0, 0},
         '{1, POL_ROBIN, 16'hFFFF, '{16'd50, 16'd0, 16'hFFFF, 8'd0}, 0, 0, 0, 0, 0},
         '{0, POL_ROBIN, 16'hFFFF, '{16'd51, 16'd0, 16'hFFFF, 8'hFF}, 1, 0, 0, 0, 0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         if (row.cfg_en) begin
            drain_results();
            write_config(row.pol, row.slc);
         end
         send_request(row.r, row.last);
         if (row.has_exp) begin
            finish_q[finish_q.size()-1].comp = row.comp;
            finish_q[finish_q.size()-1].tat  = row.tat;
            finish_q[finish_q.size()-1].wt   = row.wt;
         end
      end

      phase = 0;
      while (request_count < 200) begin
         drain_results();
         case (phase % 7)
            0: write_config(POL_FCFS, BUR_W'($urandom()));
            1: write_config(POL_SHORTEST, BUR_W'($urandom()));
            2: write_config(POL_PRIORITY, BUR_W'($urandom()));
            3: write_config(POL_ROBIN, 16'd1);
            4: write_config(POL_ROBIN, 16'hFFFF);
            5: write_config(POL_ROBIN, 16'd0);
            default: write_config(POL_ROBIN, BUR_W'($urandom_range(2, 9)));
         endcase
         if (phase == 2) hold_request = 1'b1;
         slc = cur_slice;
         repeat (3) begin
            case ($urandom_range(0, 9))
               0:       set_size = MAX_PROCS_DEF;
               1:       set_size = $urandom_range(MAX_PROCS_DEF + 1, MAX_PROCS_DEF + 2);
               default: set_size = $urandom_range(1, 6);
            endcase
            for (int k = 0; k < set_size; k++) begin
               r = random_record(slc);
               send_request(r, k == set_size - 1);
            end
         end
         phase++;
      end
      drain_results();

      if (error_count == 0)
         $display("PASS process_schedule_evaluator");
      else
         $display("FAIL process_schedule_evaluator");
      $finish;
   end

endmodule

`default_nettype wire
